// ===== rtl/binary_image_thinning_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binary image thinning block
// Shared concurrent assertion forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef BINARY_IMAGE_THINNING_MACROS_SVH
`define BINARY_IMAGE_THINNING_MACROS_SVH

// Condition holds at every edge outside reset.
`define BIT_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define BIT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bit_pkg.sv =====
// ----------------------------------------------------------------------------
// bit_pkg
// Types, constants and the per-row thinning function of the thinning block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bit_pkg;

   localparam int IMG_SIZE = 64;
   localparam int ROW_W    = 64;
   localparam int COORD_W  = 6;
   localparam int AW       = $clog2(IMG_SIZE);
   localparam int CNT_W    = $clog2(IMG_SIZE + 1);
   localparam int PASS_W   = 12;
   localparam logic [PASS_W-1:0] PASS_MAX = '1;

   localparam logic REPLY_ROW = 1'b0;
   localparam logic REPLY_RUN = 1'b1;

   typedef enum logic [2:0] {
      ACT_WRITE = 3'd0,
      ACT_START = 3'd1,
      ACT_END   = 3'd2,
      ACT_RUN   = 3'd3,
      ACT_READ  = 3'd4
   } act_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RMW,
      ST_READ,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic accept;
      logic run_start;
      logic wr_back;
      logic load_row;
      logic sweep_step;
      logic sweep_restart;
      logic load_run;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic sweep_last;
      logic sweep_any;
   } stat_type;

   // Deletion marks for row x from its upper, own and lower rows.
   function automatic logic [ROW_W-1:0] thin_row(
      input logic [ROW_W-1:0]     top,
      input logic [ROW_W-1:0]     mid,
      input logic [ROW_W-1:0]     bot,
      input logic                 sub,
      input logic [COORD_W-1:0]   x,
      input logic [2*COORD_W-1:0] start_pt,
      input logic [2*COORD_W-1:0] end_pt,
      input logic                 end_vld
   );
      logic [ROW_W-1:0]     del;
      logic [8:1]           n;
      logic [3:0]           set_cnt;
      logic [3:0]           trans;
      logic [2*COORD_W-1:0] p;
      logic                 kept;
      logic                 blocked;
      del = '0;
      for (int y = 1; y < IMG_SIZE - 1; y++) begin
         n[1] = top[y];
         n[2] = top[y+1];
         n[3] = mid[y+1];
         n[4] = bot[y+1];
         n[5] = bot[y];
         n[6] = bot[y-1];
         n[7] = mid[y-1];
         n[8] = top[y-1];
         set_cnt = '0;
         trans   = '0;
         for (int k = 1; k <= 8; k++) begin
            set_cnt = set_cnt + 4'(n[k]);
            trans   = trans + 4'(!n[k] && n[(k % 8) + 1]);
         end
         p    = {x, COORD_W'(y)};
         kept = (p == start_pt) || (end_vld && p == end_pt);
         if (sub == 1'b0)
            blocked = (n[1] && n[3] && n[5]) || (n[3] && n[4] && n[7]);
         else
            blocked = (n[1] && n[3] && n[7]) || (n[1] && n[5] && n[7]);
         del[y] = mid[y] && !kept && set_cnt >= 4'd2 && set_cnt <= 4'd6 &&
                  trans == 4'd1 && !blocked;
      end
      return del;
   endfunction

endpackage

// ===== rtl/bit_ctrl.sv =====
// ----------------------------------------------------------------------------
// bit_ctrl
// Sequencer: accepts transactions and steps the datapath through each action.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_image_thinning_macros.svh"

module bit_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_action,
   output bit_pkg::cmd_type cmd,
   input  bit_pkg::stat_type stat
);
   import bit_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   assign accept = req_valid && stat.rsp_free && (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = stat.rsp_free;
            cmd.accept = accept;
            if (accept) begin
               priority case (req_action)
                  ACT_WRITE, ACT_START, ACT_END: state_in = ST_RMW;
                  ACT_RUN: begin
                     cmd.run_start = 1'b1;
                     state_in      = ST_SWEEP;
                  end
                  ACT_READ: state_in = ST_READ;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_RMW: begin
            cmd.wr_back = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_READ: begin
            cmd.load_row = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               if (stat.sweep_any) begin
                  cmd.sweep_restart = 1'b1;
               end else begin
                  cmd.load_run = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `BIT_ASSERT_NEXT(a_run_enters_sweep, clock, reset, accept && req_action == ACT_RUN, state_ff == ST_SWEEP, "run did not start a sweep")
   `BIT_ASSERT_ALWAYS(a_no_accept_busy, clock, reset, !(state_ff == ST_SWEEP && req_ready), "ready while sweeping")
   `BIT_ASSERT_ALWAYS(a_finish_at_end, clock, reset, !cmd.load_run || stat.sweep_last, "run reply before end of subpass")

endmodule

// ===== rtl/bit_datapath.sv =====
// ----------------------------------------------------------------------------
// bit_datapath
// Image row memory, three-row sweep window, keep points and reply register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bit_pkg::cmd_type      cmd,
   output bit_pkg::stat_type     stat,
   input  logic [2:0]            req_action,
   input  logic [5:0]            req_pos_x,
   input  logic [5:0]            req_pos_y,
   input  logic                  req_pixel_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_reply_kind,
   output logic [63:0]           rsp_row_bits,
   output logic [11:0]           rsp_pass_count
);
   import bit_pkg::*;

   logic [ROW_W-1:0]     mem [IMG_SIZE];
   logic [IMG_SIZE-1:0]  row_vld_ff;
   logic [ROW_W-1:0]     rd_ff;
   logic                 rd_vld_ff;
   logic [ROW_W-1:0]     rdata;

   logic [2:0]           act_ff;
   logic [COORD_W-1:0]   x_ff;
   logic [COORD_W-1:0]   y_ff;
   logic                 val_ff;

   logic [2*COORD_W-1:0] start_ff;
   logic [2*COORD_W-1:0] end_ff;
   logic                 end_vld_ff;

   logic [CNT_W-1:0]     cnt_ff;
   logic [ROW_W-1:0]     top_ff, mid_ff;
   logic                 sub_ff;
   logic                 any_ff;
   logic [PASS_W-1:0]    pass_ff;
   logic [PASS_W-1:0]    pass_next;

   logic                 rsp_valid_ff;
   logic                 kind_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [PASS_W-1:0]    cnt_out_ff;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [ROW_W-1:0]     wr_data;
   logic                 compute;
   logic [ROW_W-1:0]     del;
   logic [ROW_W-1:0]     bit_mask;
   logic                 inside_lat;
   logic                 inside_req;

   assign rdata      = rd_vld_ff ? rd_ff : '0;
   assign inside_lat = ({1'b0, x_ff} < CNT_W'(IMG_SIZE)) && ({1'b0, y_ff} < CNT_W'(IMG_SIZE));
   assign inside_req = ({1'b0, req_pos_x} < CNT_W'(IMG_SIZE)) &&
                       ({1'b0, req_pos_y} < CNT_W'(IMG_SIZE));
   assign bit_mask   = ROW_W'(1) << y_ff;
   assign pass_next  = (pass_ff == PASS_MAX) ? pass_ff : pass_ff + PASS_W'(1);

   // Row cnt-1 arrives this cycle; row cnt-2 is then complete.
   assign compute = cmd.sweep_step && cnt_ff >= CNT_W'(3);
   assign del     = thin_row(top_ff, mid_ff, rdata, sub_ff, COORD_W'(cnt_ff - CNT_W'(2)),
                             start_ff, end_ff, end_vld_ff);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = req_pos_x[AW-1:0];
      if (cmd.accept) begin
         rd_en = 1'b1;
      end else if (cmd.sweep_step && cnt_ff < CNT_W'(IMG_SIZE)) begin
         rd_en   = 1'b1;
         rd_addr = cnt_ff[AW-1:0];
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = x_ff[AW-1:0];
      wr_data = rdata | bit_mask;
      if (compute) begin
         wr_en   = 1'b1;
         wr_addr = AW'(cnt_ff - CNT_W'(2));
         wr_data = mid_ff & ~del;
      end else if (cmd.wr_back && inside_lat) begin
         wr_en = 1'b1;
         if (act_ff == ACT_WRITE && !val_ff)
            wr_data = rdata & ~bit_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (wr_en)
            row_vld_ff[wr_addr] <= 1'b1;
         if (rd_en)
            rd_vld_ff <= row_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff <= req_action;
         x_ff   <= req_pos_x;
         y_ff   <= req_pos_y;
         val_ff <= req_pixel_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         end_ff     <= '0;
         end_vld_ff <= 1'b0;
      end else if (cmd.accept && inside_req) begin
         if (req_action == ACT_START)
            start_ff <= {req_pos_x, req_pos_y};
         if (req_action == ACT_END) begin
            end_ff     <= {req_pos_x, req_pos_y};
            end_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sub_ff  <= 1'b0;
         any_ff  <= 1'b0;
         pass_ff <= '0;
      end else if (cmd.run_start) begin
         cnt_ff  <= '0;
         sub_ff  <= 1'b0;
         any_ff  <= 1'b0;
         pass_ff <= '0;
      end else if (cmd.sweep_restart) begin
         cnt_ff  <= '0;
         sub_ff  <= !sub_ff;
         any_ff  <= 1'b0;
         pass_ff <= pass_next;
      end else if (cmd.sweep_step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (compute && |del)
            any_ff <= 1'b1;
      end
   end

   // Window keeps the pre-subpass rows even after write-back.
   always_ff @(posedge clock) begin
      if (cmd.sweep_step) begin
         top_ff <= mid_ff;
         mid_ff <= rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_row || cmd.load_run) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_row) begin
         kind_ff    <= REPLY_ROW;
         row_ff     <= ({1'b0, x_ff} < CNT_W'(IMG_SIZE)) ? rdata : '0;
         cnt_out_ff <= '0;
      end else if (cmd.load_run) begin
         kind_ff    <= REPLY_RUN;
         row_ff     <= '0;
         cnt_out_ff <= pass_next;
      end
   end

   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign stat.sweep_last = cnt_ff == CNT_W'(IMG_SIZE);
   assign stat.sweep_any  = any_ff || (compute && |del);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply_kind = kind_ff;
   assign rsp_row_bits   = row_ff;
   assign rsp_pass_count = cnt_out_ff;

endmodule

// ===== rtl/binary_image_thinning.sv =====
// ----------------------------------------------------------------------------
// binary_image_thinning
// Zhang-Suen style thinning of a 64 by 64 binary image held in row memory.
// ----------------------------------------------------------------------------
// Pixel writes and keep points read, modify and write back one row and
// give no reply; a row read registers the row from memory and then loads it
// into the reply register. A thinning run sweeps the row memory once per
// subpass, one row per cycle through a three-row window, and presents its
// reply after its last subpass. The row memory's single read port sets this
// rate. One transaction is worked on at a time; a new one is taken once the
// previous reply is gone or leaves in that cycle.
`timescale 1ns / 1ps

module binary_image_thinning (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [5:0]  req_pos_x,
   input  logic [5:0]  req_pos_y,
   input  logic        req_pixel_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reply_kind,
   output logic [63:0] rsp_row_bits,
   output logic [11:0] rsp_pass_count
);
   import bit_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .cmd        (cmd),
      .stat       (stat)
   );

   bit_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_action),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reply_kind  (rsp_reply_kind),
      .rsp_row_bits    (rsp_row_bits),
      .rsp_pass_count  (rsp_pass_count)
   );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary image thinning block: pixel loads, keep
// points, thinning runs and row reads, checked against a behavioral model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import bit_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [63:0] row;
      logic [11:0] passes;
   } reply_t;

   typedef struct {
      logic [2:0]  act;
      logic [5:0]  x;
      logic [5:0]  y;
      logic        v;
      logic        chk;
      reply_t      want;
   } stim_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_action;
   logic [5:0]  req_pos_x;
   logic [5:0]  req_pos_y;
   logic        req_pixel_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_reply_kind;
   logic [63:0] rsp_row_bits;
   logic [11:0] rsp_pass_count;

   binary_image_thinning dut (.*);

   // model state
   logic [63:0] img [64];
   logic [11:0] keep_start;
   logic [11:0] keep_end;
   logic        keep_end_vld;

   reply_t pending_replies[$];
   int     n_err;
   int     idle_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic pixel_at(int x, int y);
      if (x < 0 || y < 0 || x > 63 || y > 63) return 1'b0;
      return img[x][y];
   endfunction

   function automatic logic marked(int x, int y, logic sub);
      logic [9:1] n;
      int         cnt;
      int         tr;
      logic [11:0] p;
      n[1] = pixel_at(x-1, y);   n[2] = pixel_at(x-1, y+1);
      n[3] = pixel_at(x, y+1);   n[4] = pixel_at(x+1, y+1);
      n[5] = pixel_at(x+1, y);   n[6] = pixel_at(x+1, y-1);
      n[7] = pixel_at(x, y-1);   n[8] = pixel_at(x-1, y-1);
      n[9] = n[1];
      cnt = 0;
      tr = 0;
      p = {6'(x), 6'(y)};
      if (!img[x][y] || p == keep_start || (keep_end_vld && p == keep_end)) return 1'b0;
      for (int k = 1; k <= 8; k++) begin
         cnt += n[k];
         tr += (!n[k] && n[k+1]);
      end
      if (cnt < 2 || cnt > 6 || tr != 1) return 1'b0;
      if (!sub) return !((n[1] && n[3] && n[5]) || (n[3] && n[4] && n[7]));
      return !((n[1] && n[3] && n[7]) || (n[1] && n[5] && n[7]));
   endfunction

   function automatic logic [11:0] thin_image();
      logic [63:0] del [64];
      logic        any;
      logic        sub;
      logic [11:0] cnt;
      sub = 1'b0;
      cnt = '0;
      forever begin
         any = 1'b0;
         for (int x = 0; x < 64; x++) del[x] = '0;
         for (int x = 1; x < 63; x++)
            for (int y = 1; y < 63; y++)
               if (marked(x, y, sub)) begin
                  del[x][y] = 1'b1;
                  any = 1'b1;
               end
         for (int x = 0; x < 64; x++) img[x] &= ~del[x];
         if (cnt != 12'hFFF) cnt++;
         if (!any) return cnt;
         sub = ~sub;
      end
   endfunction

   // apply one transaction to the model, queue its reply if any
   task automatic predict_thinning(input logic [2:0] a, input logic [5:0] x,
                                   input logic [5:0] y, input logic v);
      reply_t r;
      case (a)
         ACT_WRITE: img[x][y] = v;
         ACT_START: begin img[x][y] = 1'b1; keep_start = {x, y}; end
         ACT_END: begin
            img[x][y] = 1'b1;
            keep_end = {x, y};
            keep_end_vld = 1'b1;
         end
         ACT_RUN: begin
            r.kind = REPLY_RUN; r.row = '0; r.passes = thin_image();
            pending_replies = {pending_replies, r};
         end
         ACT_READ: begin
            r.kind = REPLY_ROW; r.row = img[x]; r.passes = '0;
            pending_replies = {pending_replies, r};
         end
         default: ;
      endcase
   endtask

   // response checker and receiver stall pattern
   always @(posedge clock) begin
      reply_t w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $error("unexpected reply kind=%0d", rsp_reply_kind);
            n_err++;
         end else begin
            w = pending_replies.pop_front();
            if (rsp_reply_kind !== w.kind) begin
               $error("reply_kind exp %0d got %0d", w.kind, rsp_reply_kind); n_err++;
            end
            if (rsp_row_bits !== w.row) begin
               $error("row_bits exp %h got %h", w.row, rsp_row_bits); n_err++;
            end
            if (rsp_pass_count !== w.passes) begin
               $error("pass_count exp %0d got %0d", w.passes, rsp_pass_count); n_err++;
            end
         end
      end
   end

   int stall_phase;
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9]) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 400000) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   int burst_left;
   int n_sent;

   task automatic send(input logic [2:0] a, input logic [5:0] x,
                       input logic [5:0] y, input logic v);
      if (burst_left == 0) begin
         // valid is already low here
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      n_sent++;
      req_valid <= 1'b1;
      req_action <= a;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pixel_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_thinning(a, x, y, v);
      @(negedge clock);
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   stim_t directed[$];

   function automatic stim_t mk(logic [2:0] a, int x, int y, int v, logic c = 1'b0,
                                reply_t w = '0);
      stim_t s;
      s.act = a; s.x = 6'(x); s.y = 6'(y); s.v = 1'(v); s.chk = c; s.want = w;
      return s;
   endfunction

   function automatic void add_row(stim_t s);
      directed = {directed, s};
   endfunction

   // random blob followed by optional keeps, illegal action and run, then readback
   task automatic random_shape();
      int cx, cy, w, h;
      cx = $urandom_range(0, 63);
      cy = $urandom_range(0, 63);
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      repeat ($urandom_range(4, 20))
         send(ACT_WRITE, 6'((cx + $urandom_range(0, w)) % 64),
              6'((cy + $urandom_range(0, h)) % 64), ($urandom_range(0, 5) != 0));
      if ($urandom_range(0, 2) == 0)
         send(ACT_START, 6'(cx + 1), 6'(cy + 1), 1'($urandom));
      if ($urandom_range(0, 2) == 0)
         send(ACT_END, 6'(cx + w), 6'(cy + h), 1'($urandom));
      if ($urandom_range(0, 9) == 0) send(3'($urandom_range(5, 7)), 6'($urandom),
                                           6'($urandom), 1'($urandom));
      if ($urandom_range(0, 3) != 0) send(ACT_RUN, 6'($urandom), 6'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 4))
         send(ACT_READ, 6'((cx + $urandom_range(0, w)) % 64), 6'($urandom), 1'($urandom));
   endtask

   initial begin
      reply_t z;
      reply_t w;
      z = '0;
      n_err = 0;
      burst_left = 0;
      n_sent = 0;
      stall_phase = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_WRITE;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pixel_value = 1'b0;
      rsp_ready = 1'b1;
      for (int i = 0; i < 64; i++) img[i] = '0;
      keep_start = '0;
      keep_end = '0;
      keep_end_vld = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      w = z; w.kind = REPLY_RUN; w.passes = 12'd1;
      add_row(mk(ACT_READ, 0, 0, 0, 1'b1, z));
      add_row(mk(ACT_READ, 63, 0, 0, 1'b1, z));
      add_row(mk(ACT_RUN, 0, 0, 0, 1'b1, w));
      add_row(mk(ACT_WRITE, 0, 0, 1));
      add_row(mk(ACT_WRITE, 63, 63, 1));
      add_row(mk(ACT_WRITE, 0, 63, 1));
      add_row(mk(ACT_WRITE, 63, 0, 1));
      for (int y = 10; y < 14; y++) begin
         add_row(mk(ACT_WRITE, 10, y, 1));
         add_row(mk(ACT_WRITE, 11, y, 1));
      end
      add_row(mk(ACT_START, 10, 10, 0));
      add_row(mk(ACT_END, 11, 13, 0));
      add_row(mk(ACT_WRITE, 12, 12, 0));
      add_row(mk(3'd5, 63, 63, 1));
      add_row(mk(3'd7, 42, 21, 0));
      add_row(mk(ACT_RUN, 63, 63, 1));
      add_row(mk(ACT_READ, 10, 0, 0));
      add_row(mk(ACT_READ, 11, 63, 1));
      add_row(mk(ACT_READ, 63, 0, 0));
      add_row(mk(ACT_READ, 0, 42, 1));
      foreach (directed[i]) begin
         if (directed[i].chk) begin
            send(directed[i].act, directed[i].x, directed[i].y, directed[i].v);
            // typed-in value must agree with the model's reply just queued
            if (pending_replies[$] !== directed[i].want) begin
               $error("directed row %0d: reply exp %h model %h", i,
                      directed[i].want, pending_replies[$]);
               n_err++;
            end
         end else begin
            send(directed[i].act, directed[i].x, directed[i].y, directed[i].v);
         end
      end

      while (n_sent < 1200) begin
         if ($urandom_range(0, 9) == 0)
            send(3'($urandom_range(0, 7)), 6'($urandom), 6'($urandom), 1'($urandom));
         else
            random_shape();
      end
      if (burst_left != 0) req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (n_err == 0 && pending_replies.size() == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end
endmodule
